/* rtl/core/i2c_master_byte_engine_defines.svh */
// Assertion macros used by the checker file of the I2C master byte engine.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/i2cm_pkg.sv */
// Package with the request and result types, codes and constants of the I2C master.
package i2cm_pkg;

  // Command codes carried in the operation field.
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_ACK   = 3'd4;

  // Reset value of the half period register.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

  // Bit slots of a byte transfer; the write adds one acknowledge slot.
  localparam logic [3:0] BYTE_BITS  = 4'd8;
  localparam logic [3:0] WRITE_SLOTS = 4'd9;

  // Segment position within a command.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ONE   = 4'b0010,
    PH_TWO   = 4'b0100,
    PH_THREE = 4'b1000
  } phase_t;

  // One tick request.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       sda_in;
  } tick_t;

  // One tick result.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       cmd_rejected;
  } result_t;

endpackage

/* rtl/core/i2cm_seq.sv */
// Bus sequencer: holds the command state and computes one tick's result and next state.
module i2cm_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  i2cm_pkg::tick_t  tick,
  input  logic [15:0]      half_period,
  output i2cm_pkg::result_t res
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [2:0]  current_op, current_op_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] tick_count, tick_count_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        ack_flag, ack_flag_next;
  logic [7:0]  read_byte_reg, read_byte_reg_next;
  logic        rejected, done, busy;
  logic [15:0] hp_eff;
  logic        simple_op;

  // A zero half period behaves as one tick.
  assign hp_eff = (half_period == 16'd0) ? 16'd1 : half_period;

  // Next state and result for the request at the port.
  always_comb begin
    phase_next         = phase;
    current_op_next    = current_op;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    tick_count_next    = tick_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    ack_flag_next      = ack_flag;
    read_byte_reg_next = read_byte_reg;
    rejected           = 1'b0;
    done               = 1'b0;
    busy               = 1'b0;
    simple_op          = 1'b0;

    // Command intake: only legal codes are taken, and only while idle.
    if (phase == i2cm_pkg::PH_IDLE) begin
      if (tick.cmd_valid) begin
        if (tick.operation <= i2cm_pkg::OP_ACK) begin
          current_op_next = tick.operation;
          phase_next      = i2cm_pkg::PH_ONE;
          bit_count_next  = 4'd0;
          tick_count_next = 16'd0;
          if (tick.operation == i2cm_pkg::OP_WRITE) begin
            shift_reg_next = tick.write_data;
          end else if (tick.operation == i2cm_pkg::OP_ACK) begin
            shift_reg_next = {7'd0, tick.ack_to_send};
          end else begin
            shift_reg_next = 8'd0;
          end
        end else begin
          rejected = 1'b1;
        end
      end
    end else if (tick.cmd_valid) begin
      rejected = 1'b1;
    end

    simple_op = (current_op_next == i2cm_pkg::OP_START) ||
                (current_op_next == i2cm_pkg::OP_STOP) ||
                (current_op_next == i2cm_pkg::OP_ACK);

    if (phase_next != i2cm_pkg::PH_IDLE) begin
      busy = 1'b1;

      // Line levels for the current segment.
      if (current_op_next == i2cm_pkg::OP_START) begin
        scl_level_next = (phase_next != i2cm_pkg::PH_THREE);
        sda_level_next = (phase_next == i2cm_pkg::PH_ONE);
      end else if (current_op_next == i2cm_pkg::OP_STOP) begin
        scl_level_next = (phase_next != i2cm_pkg::PH_ONE);
        sda_level_next = (phase_next == i2cm_pkg::PH_THREE);
      end else if (current_op_next == i2cm_pkg::OP_ACK) begin
        scl_level_next = (phase_next == i2cm_pkg::PH_TWO);
        sda_level_next = !shift_reg_next[0];
      end else begin
        scl_level_next = (phase_next == i2cm_pkg::PH_TWO);
        sda_level_next = 1'b1;
        if ((current_op_next == i2cm_pkg::OP_WRITE) && (phase_next != i2cm_pkg::PH_THREE) &&
            (bit_count_next < i2cm_pkg::BYTE_BITS)) begin
          sda_level_next = shift_reg_next[7];
        end
      end

      // Segment timer and segment advance.
      if (({1'b0, tick_count_next} + 17'd1) >= {1'b0, hp_eff}) begin
        tick_count_next = 16'd0;
        if (simple_op) begin
          if (phase_next == i2cm_pkg::PH_THREE) begin
            phase_next = i2cm_pkg::PH_IDLE;
            done       = 1'b1;
          end else if (phase_next == i2cm_pkg::PH_ONE) begin
            phase_next = i2cm_pkg::PH_TWO;
          end else begin
            phase_next = i2cm_pkg::PH_THREE;
          end
        end else if (phase_next == i2cm_pkg::PH_ONE) begin
          phase_next = i2cm_pkg::PH_TWO;
        end else if (phase_next == i2cm_pkg::PH_TWO) begin
          if (current_op_next == i2cm_pkg::OP_WRITE) begin
            // Data bit shifts out; the acknowledge slot samples SDA.
            if (bit_count_next >= i2cm_pkg::BYTE_BITS) begin
              ack_flag_next = !tick.sda_in;
            end else begin
              shift_reg_next = {shift_reg_next[6:0], 1'b0};
            end
            bit_count_next = bit_count_next + 4'd1;
            phase_next = (bit_count_next >= i2cm_pkg::WRITE_SLOTS) ?
                         i2cm_pkg::PH_THREE : i2cm_pkg::PH_ONE;
          end else begin
            // Read bit sampled at the end of SCL high.
            shift_reg_next = {shift_reg_next[6:0], tick.sda_in};
            bit_count_next = bit_count_next + 4'd1;
            if (bit_count_next >= i2cm_pkg::BYTE_BITS) begin
              read_byte_reg_next = shift_reg_next;
              phase_next         = i2cm_pkg::PH_THREE;
            end else begin
              phase_next = i2cm_pkg::PH_ONE;
            end
          end
        end else begin
          phase_next = i2cm_pkg::PH_IDLE;
          done       = 1'b1;
        end
      end else begin
        tick_count_next = tick_count_next + 16'd1;
      end
    end

    res.scl_out      = scl_level_next;
    res.sda_out      = sda_level_next;
    res.busy_res     = busy;
    res.done_res     = done;
    res.read_data    = read_byte_reg_next;
    res.ack_received = ack_flag_next;
    res.cmd_rejected = rejected;
  end

  // State update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cm_pkg::PH_IDLE;
      current_op    <= i2cm_pkg::OP_START;
      bit_count     <= 4'd0;
      shift_reg     <= 8'd0;
      tick_count    <= 16'd0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      ack_flag      <= 1'b0;
      read_byte_reg <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      current_op    <= current_op_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      tick_count    <= tick_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      ack_flag      <= ack_flag_next;
      read_byte_reg <= read_byte_reg_next;
    end
  end

endmodule

/* rtl/core/i2c_master_byte_engine.sv */
// Top level of the I2C master byte engine: config register, sequencer and result buffer.
//
//   channel   direction  handshake                  payload
//   tick      in         tick_valid / tick_stall     i2cm_pkg::tick_t
//   result    out        result_valid / result_stall i2cm_pkg::result_t
//   cfg       in         cfg_write                  cfg_data (half period)
//
// One request is taken per clock while tick_stall is low; its result is registered.
// The sequencer state and result come from one short combinational step.
// A two-entry result buffer (output register plus skid) lets requests flow
// while a result waits; tick_stall rises only when both entries are full.
// Synchronous reset clears the state; no clearing pass is needed.
module i2c_master_byte_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  i2cm_pkg::tick_t   tick,
  output logic              result_valid,
  input  logic              result_stall,
  output i2cm_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data
);

  logic [15:0]       half_period;
  logic              step;
  logic              out_take;
  logic              skid_valid;
  i2cm_pkg::result_t skid;
  i2cm_pkg::result_t res_new;

  assign step       = tick_valid && !tick_stall;
  assign out_take   = result_valid && !result_stall;
  assign tick_stall = skid_valid;

  // Half period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      half_period <= cfg_data;
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .tick        (tick),
    .half_period (half_period),
    .res         (res_new)
  );

  // Result buffer occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (step) begin
      if (!result_valid || out_take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (step) begin
      if (!result_valid || out_take) begin
        result <= res_new;
      end else begin
        skid <= res_new;
      end
    end else if (out_take && skid_valid) begin
      result <= skid;
    end
  end

endmodule

/* rtl/core/i2cm_checker.sv */
// Port-level checker for the I2C master byte engine and its bind.
`include "i2c_master_byte_engine_defines.svh"

module i2cm_checker (
  input logic              clk,
  input logic              rst,
  input logic              tick_valid,
  input logic              tick_stall,
  input i2cm_pkg::result_t result,
  input logic              result_valid,
  input logic              result_stall
);

  // A stalled result stays put.
  `I2CM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

  // The request side stalls only when a result is waiting.
  `I2CM_ASSERT_NOW(a_stall_needs_result, tick_stall, result_valid, "request stalled with no result pending")

  // A request taken into an empty buffer shows its result next cycle.
  `I2CM_ASSERT_NEXT(a_request_to_result, tick_valid && !tick_stall && !result_valid, result_valid, "accepted request produced no result")

  // A finishing tick is always part of a busy sequence.
  `I2CM_ASSERT_NOW(a_done_is_busy, result_valid && result.done_res, result.busy_res, "done reported outside a busy sequence")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick_valid),
  .tick_stall   (tick_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the I2C master byte engine: scripted and random ticks.
`timescale 1ns / 100ps

module testbench;
  import i2cm_pkg::*;

  // Operation codes the engine does not define; it must flag and ignore them.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // Results that can be written down directly from the reset state.
  localparam result_t IDLE_AFTER_RESET  = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam result_t REJECTED_AT_IDLE  = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
  localparam result_t START_OPENS       = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam result_t REJECTED_IN_START = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};
  localparam result_t NO_TYPED_RESULT   = '0;

  // One line of the scripted part: a register write or one tick.
  typedef struct packed {
    logic        set_hp;
    logic [15:0] hp;
    tick_t       t;
    logic        run_out;
    logic        typed;
    result_t     want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  tick_t       tick = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;

  i2c_master_byte_engine dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the sequencer state, starting from its reset values.
  logic [15:0] hp_reg = HALF_PERIOD_RESET;
  phase_t      ph = PH_IDLE;
  logic [2:0]  cur_op = OP_START;
  logic [3:0]  nbits = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] tcount = '0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        ack_q = 1'b0;
  logic [7:0]  rd_q = '0;

  result_t     expected_results[$];
  script_row_t directed_rows[$];
  logic [2:0]  op_plan[$];
  int          burst_left = 0;
  int          ticks_sent = 0;
  int          settings_used = 0;
  int          commands_done = 0;
  int          commands_rejected = 0;
  int          mismatches = 0;
  logic [7:0]  stall_count = '0;
  logic [1:0]  stall_mode = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the engine hangs or loses results.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Advances the shadow sequencer by one tick and returns the result it should give.
  function automatic result_t advance_engine(input tick_t t);
    result_t     r;
    logic        rej;
    logic        done;
    logic        busy;
    logic [16:0] span;
    rej = 1'b0;
    done = 1'b0;
    busy = 1'b0;
    span = (hp_reg == 16'd0) ? 17'd1 : {1'b0, hp_reg};

    // Accept a command only when idle; anything else is flagged.
    if (ph == PH_IDLE) begin
      if (t.cmd_valid) begin
        if (t.operation <= OP_ACK) begin
          cur_op = t.operation;
          ph = PH_ONE;
          nbits = '0;
          tcount = '0;
          if (t.operation == OP_WRITE) shreg = t.write_data;
          else if (t.operation == OP_ACK) shreg = {7'd0, t.ack_to_send};
          else shreg = '0;
        end else begin
          rej = 1'b1;
        end
      end
    end else if (t.cmd_valid) begin
      rej = 1'b1;
    end

    if (ph != PH_IDLE) begin
      busy = 1'b1;

      // Bus levels for the current segment.
      case (cur_op)
        OP_START: begin
          scl_q = (ph != PH_THREE);
          sda_q = (ph == PH_ONE);
        end
        OP_STOP: begin
          scl_q = (ph != PH_ONE);
          sda_q = (ph == PH_THREE);
        end
        OP_ACK: begin
          scl_q = (ph == PH_TWO);
          sda_q = ~shreg[0];
        end
        default: begin
          scl_q = (ph == PH_TWO);
          sda_q = 1'b1;
          if (cur_op == OP_WRITE && ph != PH_THREE && nbits < BYTE_BITS) sda_q = shreg[7];
        end
      endcase

      // Segment end: step the phase, shift data and sample SDA at the high half.
      if ({1'b0, tcount} + 17'd1 >= span) begin
        tcount = '0;
        if (cur_op == OP_START || cur_op == OP_STOP || cur_op == OP_ACK) begin
          case (ph)
            PH_ONE: ph = PH_TWO;
            PH_TWO: ph = PH_THREE;
            default: begin
              ph = PH_IDLE;
              done = 1'b1;
            end
          endcase
        end else begin
          case (ph)
            PH_ONE: ph = PH_TWO;
            PH_TWO: begin
              if (cur_op == OP_WRITE) begin
                if (nbits >= BYTE_BITS) ack_q = ~t.sda_in;
                else shreg = {shreg[6:0], 1'b0};
                nbits = nbits + 4'd1;
                ph = (nbits >= WRITE_SLOTS) ? PH_THREE : PH_ONE;
              end else begin
                shreg = {shreg[6:0], t.sda_in};
                nbits = nbits + 4'd1;
                if (nbits >= BYTE_BITS) begin
                  rd_q = shreg;
                  ph = PH_THREE;
                end else begin
                  ph = PH_ONE;
                end
              end
            end
            default: begin
              ph = PH_IDLE;
              done = 1'b1;
            end
          endcase
        end
      end else begin
        tcount = tcount + 16'd1;
      end
    end

    r.scl_out = scl_q;
    r.sda_out = sda_q;
    r.busy_res = busy;
    r.done_res = done;
    r.read_data = rd_q;
    r.ack_received = ack_q;
    r.cmd_rejected = rej;
    return r;
  endfunction

  // Presents one request, waits until it is taken, then records its expected result.
  task automatic send_tick(input tick_t t, input logic typed, input result_t typed_res);
    result_t predicted;
    tick_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    predicted = advance_engine(t);
    expected_results.push_back(typed ? typed_res : predicted);
    ticks_sent++;

    // The sender works in bursts; most bursts are followed by a short gap.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        tick_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Random payload with no command; callers set what matters.
  function automatic tick_t random_tick();
    tick_t       t;
    logic [31:0] bits;
    bits = $urandom;
    t.cmd_valid = 1'b0;
    t.operation = bits[2:0];
    t.write_data = bits[10:3];
    t.ack_to_send = bits[11];
    t.sda_in = bits[12];
    return t;
  endfunction

  // Feeds plain ticks until the running command has finished.
  task automatic finish_command(input logic sda);
    tick_t t;
    while (ph != PH_IDLE) begin
      t = random_tick();
      t.sda_in = sda;
      send_tick(t, 1'b0, NO_TYPED_RESULT);
    end
  endtask

  // Writes the half period once the result side has drained and the pipe is quiet.
  task automatic set_half_period(input logic [15:0] value);
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    hp_reg = value;
    settings_used++;
  endtask

  // Picks the next random tick: mostly whole bus transactions, some noise.
  task automatic pick_random_tick(output tick_t t);
    logic [2:0] junk_op;
    int         n;
    t = random_tick();
    if (ph == PH_IDLE) begin
      if ($urandom_range(0, 5) != 0) begin
        if (op_plan.size() == 0) begin
          if ($urandom_range(0, 9) < 8) begin
            op_plan.push_back(OP_START);
            op_plan.push_back(OP_WRITE);
            n = $urandom_range(1, 3);
            repeat (n) begin
              if ($urandom_range(0, 1) != 0) begin
                op_plan.push_back(OP_WRITE);
              end else begin
                op_plan.push_back(OP_READ);
                op_plan.push_back(OP_ACK);
              end
            end
            op_plan.push_back(OP_STOP);
          end else begin
            junk_op = 3'($urandom_range(0, 7));
            op_plan.push_back(junk_op);
          end
        end
        t.cmd_valid = 1'b1;
        t.operation = op_plan.pop_front();
      end
    end else if ($urandom_range(0, 24) == 0) begin
      t.cmd_valid = 1'b1;
    end
  endtask

  task automatic cfg_row(input logic [15:0] hp);
    script_row_t row;
    row = '0;
    row.set_hp = 1'b1;
    row.hp = hp;
    directed_rows.push_back(row);
  endtask

  task automatic tick_row(input logic v, input logic [2:0] op, input logic [7:0] data,
                          input logic ack, input logic sda, input logic run_out,
                          input logic typed, input result_t want);
    script_row_t row;
    row = '0;
    row.t.cmd_valid = v;
    row.t.operation = op;
    row.t.write_data = data;
    row.t.ack_to_send = ack;
    row.t.sda_in = sda;
    row.run_out = run_out;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compares one result against the oldest expectation.
  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result arrived with no request pending: %h", got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("scl_out", {7'd0, want.scl_out}, {7'd0, got.scl_out});
      check_field("sda_out", {7'd0, want.sda_out}, {7'd0, got.sda_out});
      check_field("busy_res", {7'd0, want.busy_res}, {7'd0, got.busy_res});
      check_field("done_res", {7'd0, want.done_res}, {7'd0, got.done_res});
      check_field("read_data", want.read_data, got.read_data);
      check_field("ack_received", {7'd0, want.ack_received}, {7'd0, got.ack_received});
      check_field("cmd_rejected", {7'd0, want.cmd_rejected}, {7'd0, got.cmd_rejected});
      if (got.done_res === 1'b1) commands_done++;
      if (got.cmd_rejected === 1'b1) commands_rejected++;
    end
  endtask

  // Result side: check what is taken, and stall in modes that change whenever the low six bits of stall_count are zero.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      stall_count <= stall_count + 8'd1;
      if (stall_count[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 2));
      case (stall_mode)
        2'd0: result_stall <= 1'b0;
        2'd1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= (stall_count[3:0] < 4'd7);
      endcase
    end
  end

  initial begin : stimulus
    tick_t       t;
    logic [15:0] random_hp[5];

    // Scripted part. The first rows run at the reset half period.
    tick_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, IDLE_AFTER_RESET);
    tick_row(1'b1, OP_RSVD7, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, REJECTED_AT_IDLE);
    tick_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, START_OPENS);
    tick_row(1'b1, OP_WRITE, 8'h3C, 1'b0, 1'b1, 1'b0, 1'b1, REJECTED_IN_START);
    // Shorten the half period to no more than the count already reached in this segment.
    cfg_row(16'd2);
    tick_row(1'b0, OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_WRITE, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_READ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_READ, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_ACK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_RSVD5, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_RSVD6, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_TYPED_RESULT);
    // A zero half period behaves as one; the third row lands on the done tick.
    cfg_row(16'd0);
    tick_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_WRITE, 8'h81, 1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b1, OP_WRITE, 8'h7E, 1'b0, 1'b0, 1'b1, 1'b0, NO_TYPED_RESULT);
    // Longest half period, cut short in the middle of the first segment.
    cfg_row(16'hFFFF);
    tick_row(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED_RESULT);
    tick_row(1'b0, OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED_RESULT);
    cfg_row(16'd1);
    tick_row(1'b0, OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_TYPED_RESULT);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_hp) begin
        set_half_period(directed_rows[i].hp);
      end else begin
        send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);
        if (directed_rows[i].run_out) finish_command(directed_rows[i].t.sda_in);
      end
    end

    // Random part over several half periods.
    random_hp[0] = 16'd1;
    random_hp[1] = 16'd3;
    random_hp[2] = 16'd2;
    random_hp[3] = 16'($urandom_range(4, 8));
    random_hp[4] = 16'd1;
    foreach (random_hp[i]) begin
      set_half_period(random_hp[i]);
      repeat (200) begin
        pick_random_tick(t);
        send_tick(t, 1'b0, NO_TYPED_RESULT);
      end
    end

    // Drain, then let the pipe settle.
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks under %0d half-period settings.", ticks_sent, settings_used);
    $display("Engine finished %0d commands and turned away %0d.",
             commands_done, commands_rejected);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* i2c_master_byte_engine.f */
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_byte_engine.sv
rtl/core/i2cm_checker.sv
tb/sv/testbench.sv
